[hdl/nlt_pkg.sv]
package nlt_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [19:0] SILENCE_MAX = 20'd999999;
	localparam logic signed [11:0] RADIUS_ALL = -12'sd1;

	typedef enum logic [1:0] {
		ACT_OBSERVE = 2'd0,
		ACT_TICK    = 2'd1,
		ACT_QUERY   = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STAT_REFRESHED = 3'd0,
		STAT_INSERTED  = 3'd1,
		STAT_STALE     = 3'd2,
		STAT_RANGE     = 3'd3,
		STAT_OWN       = 3'd4,
		STAT_FULL      = 3'd5,
		STAT_DONE      = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS = 2'd0,
		REG_OWN_ID = 2'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         peer_id;
		logic [31:0]        msg_time;
		logic signed [11:0] own_x;
		logic signed [11:0] own_y;
		logic signed [11:0] peer_x;
		logic signed [11:0] peer_y;
	} req_word_t;

	typedef struct packed {
		logic        accepted;
		status_t     status;
		logic        found;
		logic [19:0] silence;
	} rsp_word_t;

	typedef struct packed {
		logic [7:0]  peer;
		logic [31:0] stamp;
		logic        heard;
		logic [19:0] silence;
	} entry_t;

endpackage

[hdl/nlt_ifs.sv]
interface nlt_req_if;
	import nlt_pkg::*;
	logic      valid;
	logic      ready;
	req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nlt_rsp_if;
	import nlt_pkg::*;
	logic      valid;
	logic      ready;
	rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nlt_cfg_if;
	import nlt_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  addr;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

[hdl/nlt_ram.sv]
module nlt_ram #(
	parameter int WIDTH = 61,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/neighbor_liveness_table.sv]
// Neighbor liveness table: keeps up to TABLE_DEPTH heard peers, each with its newest
// timestamp, a heard mark and a silence counter, in one entry RAM with valid bits in
// flops. Observe, tick and query walk the RAM one entry per cycle through its single
// read port, going through scan, drain and finish before the next word is accepted;
// an observe rejected for own id or range, and the unused action, go from idle straight
// to finish. The result sits in an output register, so a new word is taken while the
// previous result still waits. Configuration writes are always ready.
module neighbor_liveness_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	nlt_req_if.sink   req,
	nlt_rsp_if.source rsp,
	nlt_cfg_if.sink   cfg
);
	import nlt_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
	localparam int EW = $bits(entry_t);

	state_t state_q, state_d;
	req_word_t item_q;
	logic early_q;
	status_t early_stat_q;
	logic [IW-1:0] cnt_q;
	logic chk_s1;
	logic [IW-1:0] idx_s1;
	logic hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	entry_t hit_ent_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic out_valid_q;
	rsp_word_t out_q, out_d;
	logic load_out, set_valid;
	logic [IW-1:0] set_idx;
	logic signed [11:0] radius_q;
	logic [7:0] own_id_q;

	logic ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t ram_wdata, rd_ent;
	logic [EW-1:0] ram_rdata;

	logic accept, in_range, any_neg;
	logic [10:0] dx, dy;

	assign rd_ent = entry_t'(ram_rdata);
	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;
	assign cfg.ready = 1'b1;

	nlt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		any_neg = req.data.own_x[11] || req.data.own_y[11] ||
			req.data.peer_x[11] || req.data.peer_y[11];
		dx = (req.data.own_x[10:0] >= req.data.peer_x[10:0]) ?
			req.data.own_x[10:0] - req.data.peer_x[10:0] :
			req.data.peer_x[10:0] - req.data.own_x[10:0];
		dy = (req.data.own_y[10:0] >= req.data.peer_y[10:0]) ?
			req.data.own_y[10:0] - req.data.peer_y[10:0] :
			req.data.peer_y[10:0] - req.data.own_y[10:0];
		if (radius_q == RADIUS_ALL) begin
			in_range = 1'b1;
		end else begin
			in_range = !any_neg && !radius_q[11] &&
				(dx <= radius_q[10:0]) && (dy <= radius_q[10:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = rd_ent;
		load_out = 1'b0;
		set_valid = 1'b0;
		set_idx = free_idx_q;
		out_d.accepted = 1'b0;
		out_d.status = STAT_DONE;
		out_d.found = 1'b0;
		out_d.silence = '0;

		if (chk_s1 && item_q.action == ACT_TICK && valid_q[idx_s1]) begin
			ram_we = 1'b1;
			if (rd_ent.heard) begin
				ram_wdata.heard = 1'b0;
				ram_wdata.silence = '0;
			end else if (rd_ent.silence < SILENCE_MAX) begin
				ram_wdata.silence = rd_ent.silence + 20'd1;
			end
		end

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SCAN;
					if (req.data.action == ACT_NONE ||
						(req.data.action == ACT_OBSERVE &&
						(req.data.peer_id == own_id_q || !in_range))) begin
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d = S_IDLE;
					if (early_q) begin
						out_d.status = early_stat_q;
					end else begin
						case (action_t'(item_q.action))
							ACT_OBSERVE: begin
								if (hit_q) begin
									if (item_q.msg_time > hit_ent_q.stamp) begin
										ram_we = 1'b1;
										ram_waddr = hit_idx_q;
										ram_wdata = hit_ent_q;
										ram_wdata.stamp = item_q.msg_time;
										ram_wdata.heard = 1'b1;
										out_d.accepted = 1'b1;
										out_d.status = STAT_REFRESHED;
									end else begin
										out_d.status = STAT_STALE;
									end
								end else if (free_q) begin
									ram_we = 1'b1;
									ram_waddr = free_idx_q;
									ram_wdata.peer = item_q.peer_id;
									ram_wdata.stamp = item_q.msg_time;
									ram_wdata.heard = 1'b1;
									ram_wdata.silence = '0;
									set_valid = 1'b1;
									out_d.accepted = 1'b1;
									out_d.status = STAT_INSERTED;
								end else begin
									out_d.status = STAT_FULL;
								end
							end
							ACT_QUERY: begin
								out_d.found = hit_q;
								out_d.silence = hit_q ? hit_ent_q.silence : '0;
							end
							default: begin
								out_d.status = STAT_DONE;
							end
						endcase
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			early_q <= 1'b0;
			cnt_q <= '0;
			chk_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			valid_q <= '0;
			out_valid_q <= 1'b0;
			radius_q <= RADIUS_ALL;
			own_id_q <= '0;
		end else begin
			if (cfg.valid) begin
				case (reg_idx_t'(cfg.addr))
					REG_RADIUS: radius_q <= cfg.data[11:0];
					REG_OWN_ID: own_id_q <= cfg.data[7:0];
					default: begin
					end
				endcase
			end

			if (accept) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
				early_q <= (req.data.action == ACT_NONE) ||
					(req.data.action == ACT_OBSERVE &&
					(req.data.peer_id == own_id_q || !in_range));
			end else if (state_q == S_SCAN && cnt_q != LAST_IDX) begin
				cnt_q <= cnt_q + IW'(1);
			end

			chk_s1 <= (state_q == S_SCAN);

			if (chk_s1) begin
				if (valid_q[idx_s1] && rd_ent.peer == item_q.peer_id && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!valid_q[idx_s1] && !free_q) begin
					free_q <= 1'b1;
				end
			end

			if (set_valid) begin
				valid_q[set_idx] <= 1'b1;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			item_q <= req.data;
			if (req.data.action == ACT_OBSERVE && req.data.peer_id == own_id_q) begin
				early_stat_q <= STAT_OWN;
			end else if (req.data.action == ACT_OBSERVE) begin
				early_stat_q <= STAT_RANGE;
			end else begin
				early_stat_q <= STAT_DONE;
			end
		end
		if (chk_s1) begin
			if (valid_q[idx_s1] && rd_ent.peer == item_q.peer_id && !hit_q) begin
				hit_idx_q <= idx_s1;
				hit_ent_q <= rd_ent;
			end
			if (!valid_q[idx_s1] && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end
endmodule
